FILE: design/hgc_pkg.sv
// Shared types, constants and the arctangent table of the heading controller.
`default_nettype none
package hgc_pkg;

    // Defaults for the top-level parameters
    localparam int CORDIC_ITER_DEF = 16;
    localparam int COORD_W_DEF     = 16;

    // Field widths fixed by the interface
    localparam int HEADING_W  = 15;
    localparam int SPEED_W    = 8;
    localparam int TURN_W     = 16;
    localparam int GAIN_W     = 12;
    localparam int RADIUS_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_RADIUS = 2'd2;

    // Reset values of configuration and goal
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 12'd205;
    localparam logic signed [SPEED_W-1:0]  SPEED_RESET  = 8'sd1;
    localparam logic [RADIUS_W-1:0]        RADIUS_RESET = 15'd128;
    localparam int                         GOAL_RESET   = -256;

    // Angle arithmetic, Q3.12 radians
    localparam int PI_Q12     = 12868;
    localparam int TWO_PI_Q12 = 25736;
    localparam int ANGLE_W    = 17;   // accumulator and error width
    localparam int CORDIC_FRAC = 16;  // extra fraction bits on the vector
    localparam int ROUND_HALF = 128;  // half an LSB of the Q4.8 gain product
    localparam int GAIN_FRAC  = 8;

    // Arctangent table
    localparam int TBL_IDX_W = 5;
    localparam int ATAN_W    = 12;

    // atan(2^-i) in Q3.12, zero beyond the table's useful length
    function automatic logic [ATAN_W-1:0] atan_q12(input logic [TBL_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 12'd3217;
            5'd1:    v = 12'd1899;
            5'd2:    v = 12'd1003;
            5'd3:    v = 12'd509;
            5'd4:    v = 12'd256;
            5'd5:    v = 12'd128;
            5'd6:    v = 12'd64;
            5'd7:    v = 12'd32;
            5'd8:    v = 12'd16;
            5'd9:    v = 12'd8;
            5'd10:   v = 12'd4;
            5'd11:   v = 12'd2;
            5'd12:   v = 12'd1;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic goal_wr;   // store goal from the input item
        logic load;      // latch deltas and heading
        logic init;      // quadrant pre-rotation, clear iteration count
        logic iter;      // one CORDIC micro-rotation
        logic err;       // clamp bearing, form and wrap heading error
        logic mul;       // gain multiply
        logic out_load;  // write output registers
        logic out_zero;  // write a zero command
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic goal_pos;   // goal x strictly positive
        logic in_box;     // pose within the arrival box
        logic iter_last;  // final CORDIC step in progress
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: design/hgc_ctrl.sv
// Sequencing state machine and output valid flag of the heading controller.
`default_nettype none
module hgc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_func,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output hgc_pkg::t_dp_cmd      o_cmd,
    input  wire hgc_pkg::t_dp_stat i_stat
);
    import hgc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOX,
        S_INIT,
        S_ITER,
        S_ERR,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_zero, n_zero;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_func) begin
                        o_cmd.goal_wr = 1'b1;
                    end else if (i_stat.goal_pos) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_BOX;
                    end
                end
            end
            S_BOX: begin
                n_zero  = i_stat.in_box;
                n_state = i_stat.in_box ? S_OUT : S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = r_zero;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: design/hgc_datapath.sv
// Goal store, configuration, CORDIC bearing unit, error wrap, gain and output registers.
`default_nettype none
module hgc_datapath #(
    parameter int CORDIC_ITERATIONS = hgc_pkg::CORDIC_ITER_DEF,
    parameter int COORD_WIDTH       = hgc_pkg::COORD_W_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hgc_pkg::t_dp_cmd                    i_cmd,
    output hgc_pkg::t_dp_stat                        o_stat,
    input  wire logic                                i_cfg_we,
    input  wire logic [hgc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [hgc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_y,
    input  wire logic signed [hgc_pkg::HEADING_W-1:0] i_heading,
    output logic signed [hgc_pkg::SPEED_W-1:0]       o_linear_speed,
    output logic signed [hgc_pkg::TURN_W-1:0]        o_turn_rate
);
    import hgc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;               // delta width
    localparam int CW = DW + CORDIC_FRAC + 2;          // CORDIC vector width
    localparam int MW = (DW > RADIUS_W) ? DW : RADIUS_W;
    localparam int IW = $clog2(CORDIC_ITERATIONS);
    localparam int PW = ANGLE_W + GAIN_W + 1;          // product width
    localparam logic signed [ANGLE_W-1:0] PI_A     = ANGLE_W'(PI_Q12);
    localparam logic signed [ANGLE_W-1:0] NEG_PI_A = ANGLE_W'(-PI_Q12);
    localparam logic signed [ANGLE_W-1:0] TWO_PI_A = ANGLE_W'(TWO_PI_Q12);

    // Configuration and goal
    logic [GAIN_W-1:0]               r_gain;
    logic signed [SPEED_W-1:0]       r_speed;
    logic [RADIUS_W-1:0]             r_radius;
    logic signed [COORD_WIDTH-1:0]   r_goal_x, r_goal_y;

    // Working registers
    logic signed [DW-1:0]            r_dx, r_dy;
    logic signed [HEADING_W-1:0]     r_hd;
    logic signed [CW-1:0]            r_x, r_y;
    logic signed [ANGLE_W-1:0]       r_z;
    logic [IW-1:0]                   r_iter;
    logic signed [ANGLE_W-1:0]       r_err;
    logic signed [PW-1:0]            r_prod;
    logic signed [SPEED_W-1:0]       r_lin;
    logic signed [TURN_W-1:0]        r_turn;

    logic [DW-1:0]                   abs_dx, abs_dy;
    logic signed [CW-1:0]            x0, y0, xs, ys;
    logic signed [ANGLE_W-1:0]       atan_v, z_clamp, e_raw, e_wrap;
    logic signed [PW-1:0]            rnd, shr;
    logic signed [TURN_W-1:0]        turn_sat;

    // Arrival box test
    always_comb begin
        abs_dx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        abs_dy = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    end

    assign o_stat.goal_pos  = !r_goal_x[COORD_WIDTH-1] && (|r_goal_x);
    assign o_stat.in_box    = (MW'(abs_dx) <= MW'(r_radius)) && (MW'(abs_dy) <= MW'(r_radius));
    assign o_stat.iter_last = (r_iter == IW'(CORDIC_ITERATIONS - 1));

    // CORDIC step operands
    always_comb begin
        x0     = CW'(r_dx) <<< CORDIC_FRAC;
        y0     = CW'(r_dy) <<< CORDIC_FRAC;
        xs     = r_x >>> r_iter;
        ys     = r_y >>> r_iter;
        atan_v = $signed(ANGLE_W'(atan_q12(TBL_IDX_W'(r_iter))));
    end

    // Bearing clamp and heading error wrap
    always_comb begin
        if (r_z > PI_A) begin
            z_clamp = PI_A;
        end else if (r_z < NEG_PI_A) begin
            z_clamp = NEG_PI_A;
        end else begin
            z_clamp = r_z;
        end
        e_raw = z_clamp - ANGLE_W'(r_hd);
        if (e_raw >= PI_A) begin
            e_wrap = e_raw - TWO_PI_A;
        end else if (e_raw < NEG_PI_A) begin
            e_wrap = e_raw + TWO_PI_A;
        end else begin
            e_wrap = e_raw;
        end
    end

    // Rounding, shift and saturation of the turn rate
    always_comb begin
        rnd = r_prod + PW'(ROUND_HALF);
        shr = rnd >>> GAIN_FRAC;
        if (!shr[PW-1] && (|shr[PW-2:TURN_W-1])) begin
            turn_sat = {1'b0, {(TURN_W-1){1'b1}}};
        end else if (shr[PW-1] && !(&shr[PW-2:TURN_W-1])) begin
            turn_sat = {1'b1, {(TURN_W-1){1'b0}}};
        end else begin
            turn_sat = shr[TURN_W-1:0];
        end
    end

    // Configuration registers and goal store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_speed  <= SPEED_RESET;
            r_radius <= RADIUS_RESET;
            r_goal_x <= COORD_WIDTH'(GOAL_RESET);
            r_goal_y <= COORD_WIDTH'(GOAL_RESET);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEADING_GAIN:  r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_FORWARD_SPEED: r_speed  <= i_cfg_data[SPEED_W-1:0];
                    CFG_ARRIVE_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.goal_wr) begin
                r_goal_x <= i_pos_x;
                r_goal_y <= i_pos_y;
            end
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= DW'(r_goal_x) - DW'(i_pos_x);
            r_dy <= DW'(r_goal_y) - DW'(i_pos_y);
            r_hd <= i_heading;
        end
        // left half plane: rotate by pi first
        if (i_cmd.init) begin
            r_iter <= '0;
            if (r_dx[DW-1]) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= r_dy[DW-1] ? NEG_PI_A : PI_A;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_iter <= r_iter + 1'b1;
            if (!r_y[CW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
        end
        if (i_cmd.err) begin
            r_err <= e_wrap;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_err) * PW'($signed({1'b0, r_gain}));
        end
        if (i_cmd.out_load) begin
            r_lin  <= i_cmd.out_zero ? '0 : r_speed;
            r_turn <= i_cmd.out_zero ? '0 : turn_sat;
        end
    end

    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;

endmodule
`default_nettype wire

FILE: design/go_to_goal_heading_controller.sv
// Top level of the go-to-goal heading controller: state machine plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_func, i_pos_x, i_pos_y, i_heading
//  out     | output    | o_out_valid / i_out_ready  | o_linear_speed, o_turn_rate
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A goal update, or a pose update while goal x is not positive, ends in the idle state with no output.
// A pose update inside the arrival box goes through BOX to OUT with a zero command; outside it
// goes through BOX, INIT, the ITER steps on the single shared CORDIC stage, ERR, MUL and OUT.
// One item is worked at a time; the finished command waits in the output register
// while the next item is taken, and a full output register stalls the final step.
// Reset (synchronous, active low) restores the register defaults and a goal of (-256, -256).
`default_nettype none
module go_to_goal_heading_controller #(
    parameter int CORDIC_ITERATIONS = hgc_pkg::CORDIC_ITER_DEF,
    parameter int COORD_WIDTH       = hgc_pkg::COORD_W_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_func,
    input  wire logic signed [COORD_WIDTH-1:0]        i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_pos_y,
    input  wire logic signed [hgc_pkg::HEADING_W-1:0] i_heading,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [hgc_pkg::SPEED_W-1:0]        o_linear_speed,
    output logic signed [hgc_pkg::TURN_W-1:0]         o_turn_rate,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hgc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [hgc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import hgc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    hgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Arithmetic
    hgc_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .COORD_WIDTH       (COORD_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_heading      (i_heading),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate)
    );

endmodule
`default_nettype wire
